[design/kmer_counting_table_defines.svh]
// ----------------------------------------------------------------------------
// kmer counting table assertion macros
// shared property forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef KMER_COUNTING_TABLE_DEFINES_SVH
`define KMER_COUNTING_TABLE_DEFINES_SVH

// condition holds at every clock edge
`define KCT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// consequence holds in the same cycle
`define KCT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequence holds in the next cycle
`define KCT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/kct_pkg.sv]
// ----------------------------------------------------------------------------
// kct_pkg
// codes and fixed widths shared by the kmer counting table modules
// ----------------------------------------------------------------------------
package kct_pkg;

   localparam int BYTE_W      = 8;
   localparam int KLEN_W      = 4;
   localparam int MODE_W      = 2;
   localparam int STATUS_W    = 3;
   localparam int IDX_PORT_W  = 10;
   localparam int KEY_PORT_W  = 64;
   localparam int CNT_PORT_W  = 32;
   localparam int USED_PORT_W = 11;

   localparam logic [KLEN_W-1:0] KLEN_RESET = 4'd4;

   // request modes, the unused code acts as clear
   localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

   typedef enum logic [STATUS_W-1:0] {
      ST_FILLING      = 3'd0,
      ST_COUNTED      = 3'd1,
      ST_INSERTED     = 3'd2,
      ST_DROPPED      = 3'd3,
      ST_ENTRY_READ   = 3'd4,
      ST_OUT_OF_RANGE = 3'd5,
      ST_CLEARED      = 3'd6
   } kct_status_type;

endpackage

[design/kct_ram.sv]
// ----------------------------------------------------------------------------
// kct_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module kct_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/kct_window.sv]
// ----------------------------------------------------------------------------
// kct_window
// byte window of the last MAX_K bytes and the masked k-mer taken from it
// ----------------------------------------------------------------------------
module kct_window #(
   parameter int MAX_K = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               shift_en,
   input  logic                               clear_en,
   input  logic [kct_pkg::BYTE_W-1:0]         data_byte,
   input  logic [kct_pkg::KLEN_W-1:0]         kmer_length,
   output logic [kct_pkg::BYTE_W*MAX_K-1:0]   key,
   output logic                               key_ready
);

   import kct_pkg::*;

   localparam int WIN_W = BYTE_W * MAX_K;
   localparam int KC_W  = $clog2(MAX_K + 1);

   logic [WIN_W-1:0] window_ff, window_in;
   logic [KC_W-1:0]  seen_ff, seen_in;
   logic [KC_W-1:0]  k_eff;

   // length 0 acts as 1, above MAX_K acts as MAX_K
   always_comb begin
      if (kmer_length == '0) begin
         k_eff = KC_W'(1);
      end else if (kmer_length > KLEN_W'(MAX_K)) begin
         k_eff = KC_W'(MAX_K);
      end else begin
         k_eff = KC_W'(kmer_length);
      end
   end

   always_comb begin
      window_in = window_ff;
      seen_in   = seen_ff;
      if (clear_en) begin
         window_in = '0;
         seen_in   = '0;
      end else if (shift_en) begin
         window_in = (window_ff << BYTE_W) | WIN_W'(data_byte);
         if (seen_ff < KC_W'(MAX_K)) begin
            seen_in = seen_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         seen_ff   <= '0;
      end else begin
         window_ff <= window_in;
         seen_ff   <= seen_in;
      end
   end

   // keep the newest k byte lanes
   always_comb begin
      for (int j = 0; j < MAX_K; j++) begin
         key[j*BYTE_W +: BYTE_W] = (j < int'(k_eff)) ? window_ff[j*BYTE_W +: BYTE_W] : '0;
      end
   end

   assign key_ready = (seen_ff >= k_eff);

endmodule

[design/kmer_counting_table.sv]
// ----------------------------------------------------------------------------
// kmer_counting_table
// counts k-mers of a byte stream in a table kept in insertion order
// ----------------------------------------------------------------------------
//  channel   ports                          direction   word
//  req       req_valid / req_ready          in          mode, byte, entry index
//  rsp       rsp_valid / rsp_ready          out         status, index, key, count, fill
//  csr       csr_wr_en / csr_wr_data        in          kmer length, no wait
//
//  a push scans the key and count stores through their single read port, one
//  stored key compared per cycle, and a hit ends the scan early
//  a read passes through the exec and read data states; a clear or a push that
//  is still filling ends in the exec state
//  reset is synchronous; the stores need no clearing pass, the fill count
//  marks the valid region so reset and clear take effect at once
//  a result waits in the output register; the next word is taken meanwhile,
//  and only its own completion stalls until the output register is free
// ----------------------------------------------------------------------------
`include "kmer_counting_table_defines.svh"

module kmer_counting_table #(
   parameter int MAX_K       = 8,
   parameter int TABLE_DEPTH = 1024,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [kct_pkg::MODE_W-1:0]          req_mode,
   input  logic [kct_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic [kct_pkg::IDX_PORT_W-1:0]      req_entry_index,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [kct_pkg::STATUS_W-1:0]        rsp_status,
   output logic [kct_pkg::IDX_PORT_W-1:0]      rsp_result_index,
   output logic [kct_pkg::KEY_PORT_W-1:0]      rsp_kmer_key,
   output logic [kct_pkg::CNT_PORT_W-1:0]      rsp_kmer_count,
   output logic [kct_pkg::USED_PORT_W-1:0]     rsp_entries_in_use,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [kct_pkg::KLEN_W-1:0]          csr_wr_data
);

   import kct_pkg::*;

   localparam int KEY_W  = BYTE_W * MAX_K;
   localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int SCAN_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W  = SCAN_W + IDX_PORT_W;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SEARCH,
      S_READ_DATA
   } state_type;

   // sequencer state
   state_type                state_ff, state_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic [IDX_PORT_W-1:0]    eidx_ff, eidx_in;
   logic [SCAN_W-1:0]        used_ff, used_in;
   logic [SCAN_W-1:0]        scan_ff, scan_in;
   logic                     cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]         cmp_idx_ff, cmp_idx_in;
   logic [KLEN_W-1:0]        kmer_length_ff, kmer_length_in;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   kct_status_type           rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [KEY_W-1:0]         rsp_key_ff, rsp_key_in;
   logic [COUNT_WIDTH-1:0]   rsp_count_ff, rsp_count_in;
   logic [SCAN_W-1:0]        rsp_used_ff, rsp_used_in;

   // store ports
   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [KEY_W-1:0]         key_rd;
   logic [COUNT_WIDTH-1:0]   count_rd;
   logic                     key_we;
   logic                     cnt_we;
   logic [IDX_W-1:0]         wr_addr;
   logic [COUNT_WIDTH-1:0]   cnt_wdata;

   // window
   logic                     accept;
   logic                     win_shift;
   logic                     win_clear;
   logic [KEY_W-1:0]         win_key;
   logic                     win_ready;

   logic                     out_free;
   logic                     issue_ok;
   logic                     hit;
   logic                     read_in_range;
   logic                     hit_commit;
   logic                     ins_commit;
   logic [COUNT_WIDTH-1:0]   count_inc;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign win_shift = accept && (req_mode == MODE_PUSH);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // scan pipeline: an address is issued, and its key is compared in the next cycle
   assign issue_ok      = (scan_ff < used_ff);
   assign hit           = cmp_vld_ff && (key_rd == win_key);
   assign count_inc     = (count_rd == '1) ? count_rd : count_rd + 1'b1;
   assign read_in_range = (CMP_W'(eidx_ff) < CMP_W'(used_ff));

   assign kmer_length_in = csr_wr_en ? csr_wr_data : kmer_length_ff;

   kct_window #(
      .MAX_K (MAX_K)
   ) u_window (
      .clock       (clock),
      .reset       (reset),
      .shift_en    (win_shift),
      .clear_en    (win_clear),
      .data_byte   (req_data_byte),
      .kmer_length (kmer_length_ff),
      .key         (win_key),
      .key_ready   (win_ready)
   );

   kct_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_key_store (
      .clock   (clock),
      .wr_en   (key_we),
      .wr_addr (wr_addr),
      .wr_data (win_key),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   kct_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_count_store (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (wr_addr),
      .wr_data (cnt_wdata),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (count_rd)
   );

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      eidx_in       = eidx_ff;
      used_in       = used_ff;
      scan_in       = scan_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_used_in   = rsp_used_ff;
      rd_en         = 1'b0;
      rd_addr       = IDX_W'(scan_ff);
      key_we        = 1'b0;
      cnt_we        = 1'b0;
      wr_addr       = IDX_W'(used_ff);
      cnt_wdata     = COUNT_WIDTH'(1);
      win_clear     = 1'b0;
      hit_commit    = 1'b0;
      ins_commit    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               eidx_in  = req_entry_index;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            unique case (mode_ff)
               MODE_PUSH: begin
                  if (!win_ready) begin
                     // fewer than k bytes since reset or clear
                     if (out_free) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FILLING;
                        rsp_index_in  = '0;
                        rsp_key_in    = '0;
                        rsp_count_in  = '0;
                        rsp_used_in   = used_ff;
                        state_in      = S_IDLE;
                     end
                  end else begin
                     scan_in    = '0;
                     cmp_vld_in = 1'b0;
                     state_in   = S_SEARCH;
                  end
               end
               MODE_READ: begin
                  if (read_in_range) begin
                     rd_en    = 1'b1;
                     rd_addr  = IDX_W'(eidx_ff);
                     state_in = S_READ_DATA;
                  end else if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_OUT_OF_RANGE;
                     rsp_index_in  = '0;
                     rsp_key_in    = '0;
                     rsp_count_in  = '0;
                     rsp_used_in   = used_ff;
                     state_in      = S_IDLE;
                  end
               end
               default: begin
                  // clear, and the unused mode code
                  if (out_free) begin
                     win_clear     = 1'b1;
                     used_in       = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_CLEARED;
                     rsp_index_in  = '0;
                     rsp_key_in    = '0;
                     rsp_count_in  = '0;
                     rsp_used_in   = '0;
                     state_in      = S_IDLE;
                  end
               end
            endcase
         end

         S_READ_DATA: begin
            // read data holds while the output register is busy
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_ENTRY_READ;
               rsp_index_in  = IDX_W'(eidx_ff);
               rsp_key_in    = key_rd;
               rsp_count_in  = count_rd;
               rsp_used_in   = used_ff;
               state_in      = S_IDLE;
            end
         end

         S_SEARCH: begin
            if (hit) begin
               // no new read while a hit waits, so the read data holds
               if (out_free) begin
                  hit_commit    = 1'b1;
                  cnt_we        = 1'b1;
                  wr_addr       = cmp_idx_ff;
                  cnt_wdata     = count_inc;
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_COUNTED;
                  rsp_index_in  = cmp_idx_ff;
                  rsp_key_in    = win_key;
                  rsp_count_in  = count_inc;
                  rsp_used_in   = used_ff;
                  state_in      = S_IDLE;
               end
            end else if (!issue_ok) begin
               // every stored key compared without a match
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_key_in   = win_key;
                  state_in     = S_IDLE;
                  if (used_ff == SCAN_W'(TABLE_DEPTH)) begin
                     rsp_status_in = ST_DROPPED;
                     rsp_index_in  = '0;
                     rsp_count_in  = '0;
                     rsp_used_in   = used_ff;
                  end else begin
                     ins_commit    = 1'b1;
                     key_we        = 1'b1;
                     cnt_we        = 1'b1;
                     used_in       = used_ff + 1'b1;
                     rsp_status_in = ST_INSERTED;
                     rsp_index_in  = IDX_W'(used_ff);
                     rsp_count_in  = COUNT_WIDTH'(1);
                     rsp_used_in   = used_ff + 1'b1;
                  end
               end
            end else begin
               rd_en      = 1'b1;
               scan_in    = scan_ff + 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = IDX_W'(scan_ff);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      eidx_ff       <= eidx_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_used_ff   <= rsp_used_in;
      if (reset) begin
         state_ff       <= S_IDLE;
         used_ff        <= '0;
         cmp_vld_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         kmer_length_ff <= KLEN_RESET;
      end else begin
         state_ff       <= state_in;
         used_ff        <= used_in;
         cmp_vld_ff     <= cmp_vld_in;
         rsp_valid_ff   <= rsp_valid_in;
         kmer_length_ff <= kmer_length_in;
      end
   end

   // ports, widened or cut to the fixed field widths
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_index   = IDX_PORT_W'(rsp_index_ff);
   assign rsp_kmer_key       = KEY_PORT_W'(rsp_key_ff);
   assign rsp_kmer_count     = CNT_PORT_W'(rsp_count_ff);
   assign rsp_entries_in_use = USED_PORT_W'(rsp_used_ff);

   // fill count never passes the table depth
   `KCT_ASSERT_ALWAYS(a_used_bound, used_ff <= SCAN_W'(TABLE_DEPTH), "fill count above depth")

   // a compare in flight always refers to a stored entry
   `KCT_ASSERT_IMPLY(a_cmp_in_table, (state_ff == S_SEARCH) && cmp_vld_ff, SCAN_W'(cmp_idx_ff) < used_ff, "compare beyond fill")

   // an insert grows the table by exactly one
   `KCT_ASSERT_NEXT(a_insert_grows, ins_commit, used_ff == SCAN_W'($past(used_ff) + 1'b1), "insert did not grow table")

   // a hit is reported as counted in the next cycle
   `KCT_ASSERT_NEXT(a_hit_reported, hit_commit, rsp_valid_ff && (rsp_status_ff == ST_COUNTED), "hit not reported")

endmodule
